### rtl/frw_pkg.sv
// Package for the framebuffer rectangle writer.
// Holds the configuration record, register indexes, draw modes and field widths.
// No dependencies.
package frw_pkg;

  // Fixed field widths
  localparam int PITCH_W   = 14;
  localparam int BPP_W     = 3;
  localparam int ORIGIN_W  = 12;
  localparam int EXTENT_W  = 13;
  localparam int MODE_W    = 2;
  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int OUT_ADDR_W = 26;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  // Gray level that marks a transparent pixel
  localparam logic [CHAN_W-1:0] TRANSPARENT_LEVEL = 8'd1;

  // Draw modes; the unused code falls back to solid fill
  localparam logic [MODE_W-1:0] MODE_FILL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BGR  = 2'd2;

  // Register map, one word per register
  typedef enum logic [2:0] {
    REG_ROW_PITCH,
    REG_BYTES_PER_PIXEL,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_RECT_WIDTH,
    REG_RECT_HEIGHT,
    REG_DRAW_MODE,
    REG_FILL_COLOR
  } reg_index_t;

  // Configuration record shared by all stages
  typedef struct packed {
    logic [PITCH_W-1:0]  row_pitch;
    logic [BPP_W-1:0]    bytes_per_pixel;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [EXTENT_W-1:0] rect_width;
    logic [EXTENT_W-1:0] rect_height;
    logic [MODE_W-1:0]   draw_mode;
    logic [COLOR_W-1:0]  fill_color;
  } cfg_t;

endpackage

### rtl/frw_walker.sv
// Rectangle walker: column and row counters plus the input stage register.
// Depends on frw_pkg.
module frw_walker import frw_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  cfg_write,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAN_W-1:0]     src_blue,
  input  logic [CHAN_W-1:0]     src_green,
  input  logic [CHAN_W-1:0]     src_red,
  output logic                  s1_valid,
  input  logic                  s1_ready,
  output logic [CHAN_W-1:0]     s1_blue,
  output logic [CHAN_W-1:0]     s1_green,
  output logic [CHAN_W-1:0]     s1_red,
  output logic [((ORIGIN_W > COORD_BITS) ? ORIGIN_W : COORD_BITS):0] s1_row_term,
  output logic [((ORIGIN_W > COORD_BITS) ? ORIGIN_W : COORD_BITS):0] s1_col_term,
  output logic                  s1_done
);

  localparam int EXT_W  = (COORD_BITS + 1 > EXTENT_W) ? COORD_BITS + 1 : EXTENT_W;
  localparam int TERM_W = ((ORIGIN_W > COORD_BITS) ? ORIGIN_W : COORD_BITS) + 1;
  localparam logic [EXT_W-1:0] LIMIT = (EXT_W)'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] column_count, column_count_next;
  logic [COORD_BITS-1:0] row_count, row_count_next;
  logic [COORD_BITS-1:0] last_col, last_row, dest_row;
  logic [EXT_W-1:0]      width_ext, height_ext;
  logic                  col_end, row_end, accept;

  // Clamp the extents to one through the counter range
  always_comb begin
    width_ext  = (EXT_W)'(cfg.rect_width);
    height_ext = (EXT_W)'(cfg.rect_height);
    if (width_ext == '0) begin
      last_col = '0;
    end else if (width_ext > LIMIT) begin
      last_col = '1;
    end else begin
      last_col = (COORD_BITS)'(width_ext - (EXT_W)'(1));
    end
    if (height_ext == '0) begin
      last_row = '0;
    end else if (height_ext > LIMIT) begin
      last_row = '1;
    end else begin
      last_row = (COORD_BITS)'(height_ext - (EXT_W)'(1));
    end
  end

  assign col_end  = column_count >= last_col;
  assign row_end  = row_count >= last_row;
  assign in_stall = s1_valid && !s1_ready;
  assign accept   = in_valid && !in_stall;

  // Flip rows for the bottom-up copy in BGR mode
  always_comb begin
    if (cfg.draw_mode == MODE_BGR) begin
      dest_row = (row_count > last_row) ? '0 : last_row - row_count;
    end else begin
      dest_row = row_count;
    end
  end

  // Advance the counters; a register write restarts the rectangle
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (cfg_write) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (accept) begin
      if (col_end) begin
        column_count_next = '0;
        row_count_next    = row_end ? '0 : row_count + (COORD_BITS)'(1);
      end else begin
        column_count_next = column_count + (COORD_BITS)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Stage valid: set on an accepted beat, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the beat and its coordinate terms
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blue     <= src_blue;
      s1_green    <= src_green;
      s1_red      <= src_red;
      s1_row_term <= (TERM_W)'(cfg.origin_y) + (TERM_W)'(dest_row);
      s1_col_term <= (TERM_W)'(cfg.origin_x) + (TERM_W)'(column_count);
      s1_done     <= col_end && row_end;
    end
  end

  // Counters stay inside the rectangle
  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    column_count <= last_col && row_count <= last_row)
    else $error("walker counter beyond rectangle extent");

  // The last pixel returns the walk to the origin
  a_done_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && col_end && row_end |=> column_count == '0 && row_count == '0)
    else $error("walker did not restart after last pixel");

  // A stalled stage keeps its beat
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1_row_term) && $stable(s1_col_term))
    else $error("walker stage lost a stalled beat");

endmodule

### rtl/frw_pixel.sv
// Pixel stage: byte address and color bytes, held in the result register.
// Depends on frw_pkg.
module frw_pixel import frw_pkg::*; #(
  parameter int ADDR_BITS  = 26,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  s1_valid,
  output logic                  s1_ready,
  input  logic [CHAN_W-1:0]     s1_blue,
  input  logic [CHAN_W-1:0]     s1_green,
  input  logic [CHAN_W-1:0]     s1_red,
  input  logic [((ORIGIN_W > COORD_BITS) ? ORIGIN_W : COORD_BITS):0] s1_row_term,
  input  logic [((ORIGIN_W > COORD_BITS) ? ORIGIN_W : COORD_BITS):0] s1_col_term,
  input  logic                  s1_done,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_ADDR_W-1:0] byte_address,
  output logic [CHAN_W-1:0]     out_blue,
  output logic [CHAN_W-1:0]     out_green,
  output logic [CHAN_W-1:0]     out_red,
  output logic                  write_enable,
  output logic                  rect_done
);

  localparam int TERM_W = ((ORIGIN_W > COORD_BITS) ? ORIGIN_W : COORD_BITS) + 1;
  localparam int RP_W   = TERM_W + PITCH_W;
  localparam int CP_W   = TERM_W + BPP_W;
  localparam int W0     = (RP_W > CP_W) ? RP_W : CP_W;
  localparam int W1     = (W0 > ADDR_BITS) ? W0 : ADDR_BITS;
  localparam int SUM_W  = ((W1 > OUT_ADDR_W) ? W1 : OUT_ADDR_W) + 1;
  localparam logic [SUM_W-1:0] ADDR_MASK = {SUM_W{1'b1}} >> (SUM_W - ADDR_BITS);

  logic [RP_W-1:0]   row_prod;
  logic [CP_W-1:0]   col_prod;
  logic [SUM_W-1:0]  addr_sum, addr_wrap;
  logic [CHAN_W-1:0] blue, green, red;
  logic              wen, take;

  // Row offset and pixel offset, wrapped at the address width
  always_comb begin
    row_prod  = (RP_W)'(s1_row_term) * (RP_W)'(cfg.row_pitch);
    col_prod  = (CP_W)'(s1_col_term) * (CP_W)'(cfg.bytes_per_pixel);
    addr_sum  = (SUM_W)'(row_prod) + (SUM_W)'(col_prod);
    addr_wrap = addr_sum & ADDR_MASK;
  end

  // Pick the color bytes by mode
  always_comb begin
    wen = 1'b1;
    unique case (cfg.draw_mode)
      MODE_GRAY: begin
        blue  = s1_blue;
        green = s1_blue;
        red   = s1_blue;
        wen   = s1_blue != TRANSPARENT_LEVEL;
      end
      MODE_BGR: begin
        blue  = s1_blue;
        green = s1_green;
        red   = s1_red;
      end
      default: begin
        blue  = cfg.fill_color[7:0];
        green = cfg.fill_color[15:8];
        red   = cfg.fill_color[23:16];
      end
    endcase
  end

  assign s1_ready = !out_valid || !out_stall;
  assign take     = s1_valid && s1_ready;

  // Result valid: set on a taken beat, drop when delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (take) begin
      byte_address <= addr_wrap[OUT_ADDR_W-1:0];
      out_blue     <= blue;
      out_green    <= green;
      out_red      <= red;
      write_enable <= wen;
      rect_done    <= s1_done;
    end
  end

  // A skipped pixel is always a keyed gray level
  a_skip_is_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |->
      out_blue == TRANSPARENT_LEVEL && out_green == out_blue && out_red == out_blue)
    else $error("pixel skipped without transparency key");

  // A new result comes only from a filled input stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a staged beat");

  // Address bits above the wrap width stay clear
  a_addr_wrap: assert property (@(posedge clk) disable iff (rst)
    take |-> (addr_wrap & ~ADDR_MASK) == '0)
    else $error("address escaped its wrap width");

endmodule

### rtl/framebuffer_rect_writer_top.sv
// Framebuffer rectangle writer: beats pass the input stage register, then the result register.
// One pixel per cycle without out_stall; counters and address multiply stage pipeline freely.
// Reset (synchronous, active high) restores register defaults and starts at the origin.
// Any register write also restarts the walk at the rectangle origin.
// Top level: APB register file and the two pipeline stages. Depends on frw_pkg,
// frw_walker and frw_pixel.
module framebuffer_rect_writer_top import frw_pkg::*; #(
  parameter int ADDR_BITS  = 26,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAN_W-1:0]     src_blue,
  input  logic [CHAN_W-1:0]     src_green,
  input  logic [CHAN_W-1:0]     src_red,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_ADDR_W-1:0] byte_address,
  output logic [CHAN_W-1:0]     out_blue,
  output logic [CHAN_W-1:0]     out_green,
  output logic [CHAN_W-1:0]     out_red,
  output logic                  write_enable,
  output logic                  rect_done
);

  localparam int TERM_W = ((ORIGIN_W > COORD_BITS) ? ORIGIN_W : COORD_BITS) + 1;

  cfg_t              cfg;
  logic              cfg_write;
  reg_index_t        reg_sel;
  logic              s1_valid, s1_ready, s1_done;
  logic [CHAN_W-1:0] s1_blue, s1_green, s1_red;
  logic [TERM_W-1:0] s1_row_term, s1_col_term;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_index_t'(paddr[4:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_pitch       <= 14'd3072;
      cfg.bytes_per_pixel <= 3'd4;
      cfg.origin_x        <= '0;
      cfg.origin_y        <= '0;
      cfg.rect_width      <= 13'd1;
      cfg.rect_height     <= 13'd1;
      cfg.draw_mode       <= MODE_FILL;
      cfg.fill_color      <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_ROW_PITCH:       cfg.row_pitch       <= pwdata[PITCH_W-1:0];
        REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= pwdata[BPP_W-1:0];
        REG_ORIGIN_X:        cfg.origin_x        <= pwdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y:        cfg.origin_y        <= pwdata[ORIGIN_W-1:0];
        REG_RECT_WIDTH:      cfg.rect_width      <= pwdata[EXTENT_W-1:0];
        REG_RECT_HEIGHT:     cfg.rect_height     <= pwdata[EXTENT_W-1:0];
        REG_DRAW_MODE:       cfg.draw_mode       <= pwdata[MODE_W-1:0];
        REG_FILL_COLOR:      cfg.fill_color      <= pwdata[COLOR_W-1:0];
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_sel)
      REG_ROW_PITCH:       prdata = (PDATA_W)'(cfg.row_pitch);
      REG_BYTES_PER_PIXEL: prdata = (PDATA_W)'(cfg.bytes_per_pixel);
      REG_ORIGIN_X:        prdata = (PDATA_W)'(cfg.origin_x);
      REG_ORIGIN_Y:        prdata = (PDATA_W)'(cfg.origin_y);
      REG_RECT_WIDTH:      prdata = (PDATA_W)'(cfg.rect_width);
      REG_RECT_HEIGHT:     prdata = (PDATA_W)'(cfg.rect_height);
      REG_DRAW_MODE:       prdata = (PDATA_W)'(cfg.draw_mode);
      REG_FILL_COLOR:      prdata = (PDATA_W)'(cfg.fill_color);
    endcase
  end

  frw_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_write   (cfg_write),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .src_blue    (src_blue),
    .src_green   (src_green),
    .src_red     (src_red),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_blue     (s1_blue),
    .s1_green    (s1_green),
    .s1_red      (s1_red),
    .s1_row_term (s1_row_term),
    .s1_col_term (s1_col_term),
    .s1_done     (s1_done)
  );

  frw_pixel #(
    .ADDR_BITS  (ADDR_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_pixel (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .s1_blue      (s1_blue),
    .s1_green     (s1_green),
    .s1_red       (s1_red),
    .s1_row_term  (s1_row_term),
    .s1_col_term  (s1_col_term),
    .s1_done      (s1_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_address (byte_address),
    .out_blue     (out_blue),
    .out_green    (out_green),
    .out_red      (out_red),
    .write_enable (write_enable),
    .rect_done    (rect_done)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for framebuffer_rect_writer_top: directed table, then randomized phases.
// Depends on frw_pkg and the RTL under rtl/; predicts every pixel beat and compares in order.
module testbench;
  import frw_pkg::*;

  localparam int ADDR_BITS   = 26;
  localparam int COORD_BITS  = 12;
  localparam longint unsigned ADDR_MASK  = (64'd1 << ADDR_BITS) - 1;
  localparam longint unsigned COORD_SPAN = 64'd1 << COORD_BITS;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_PIXELS = 1700;
  localparam int IDLE_LIMIT    = 4000;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] addr;
    logic [CHAN_W-1:0]     blue;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     red;
    logic                  we;
    logic                  done;
  } pixel_out_t;

  typedef struct packed {
    bit          is_write;
    reg_index_t  idx;
    logic [31:0] value;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    bit          typed;
    pixel_out_t  want;
  } plan_row_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [CHAN_W-1:0] src_blue, src_green, src_red;
  logic out_valid, out_stall;
  logic [OUT_ADDR_W-1:0] byte_address;
  logic [CHAN_W-1:0] out_blue, out_green, out_red;
  logic write_enable, rect_done;

  // Predictor state: register copy plus the walk counters
  cfg_t walk_cfg;
  longint unsigned col_pos, row_pos;

  pixel_out_t expected_pixels[$];
  plan_row_t  directed_rows[$];
  int  mismatch_count = 0;
  int  idle_cycles = 0;
  int  random_sent = 0;
  bit  bus_open = 0;
  logic [11:0] stall_clock = '0;

  framebuffer_rect_writer_top #(
    .ADDR_BITS (ADDR_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .src_blue, .src_green, .src_red,
    .out_valid, .out_stall, .byte_address, .out_blue, .out_green, .out_red,
    .write_enable, .rect_done
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Zero width or height acts as one; oversize saturates to the coordinate span
  function automatic longint unsigned clamp_extent(input logic [EXTENT_W-1:0] v);
    if (v == 0) return 1;
    if (v > COORD_SPAN) return COORD_SPAN;
    return v;
  endfunction

  // Any register write restarts the walk at the rectangle origin
  function automatic void apply_register(input reg_index_t idx, input logic [31:0] value);
    case (idx)
      REG_ROW_PITCH:       walk_cfg.row_pitch       = value[PITCH_W-1:0];
      REG_BYTES_PER_PIXEL: walk_cfg.bytes_per_pixel = value[BPP_W-1:0];
      REG_ORIGIN_X:        walk_cfg.origin_x        = value[ORIGIN_W-1:0];
      REG_ORIGIN_Y:        walk_cfg.origin_y        = value[ORIGIN_W-1:0];
      REG_RECT_WIDTH:      walk_cfg.rect_width      = value[EXTENT_W-1:0];
      REG_RECT_HEIGHT:     walk_cfg.rect_height     = value[EXTENT_W-1:0];
      REG_DRAW_MODE:       walk_cfg.draw_mode       = value[MODE_W-1:0];
      REG_FILL_COLOR:      walk_cfg.fill_color      = value[COLOR_W-1:0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Work out the pixel beat for one source tick and advance the walk
  function automatic pixel_out_t predict_pixel(input logic [7:0] b, g, r);
    longint unsigned last_col, last_row, dest_row, base, addr;
    bit col_end, row_end;
    pixel_out_t res;
    last_col = clamp_extent(walk_cfg.rect_width) - 1;
    last_row = clamp_extent(walk_cfg.rect_height) - 1;
    if (walk_cfg.draw_mode == MODE_BGR) begin
      dest_row = (row_pos > last_row) ? 0 : last_row - row_pos;
    end else begin
      dest_row = row_pos;
    end
    base = ((64'(walk_cfg.origin_y) + dest_row) * 64'(walk_cfg.row_pitch)
            + 64'(walk_cfg.origin_x) * 64'(walk_cfg.bytes_per_pixel)) & ADDR_MASK;
    addr = (base + col_pos * 64'(walk_cfg.bytes_per_pixel)) & ADDR_MASK;
    res.addr = addr[OUT_ADDR_W-1:0];
    res.we = 1'b1;
    if (walk_cfg.draw_mode == MODE_GRAY) begin
      res.blue = b;
      res.green = b;
      res.red = b;
      res.we = (b != TRANSPARENT_LEVEL);
    end else if (walk_cfg.draw_mode == MODE_BGR) begin
      res.blue = b;
      res.green = g;
      res.red = r;
    end else begin
      res.blue = walk_cfg.fill_color[7:0];
      res.green = walk_cfg.fill_color[15:8];
      res.red = walk_cfg.fill_color[23:16];
    end
    col_end = (col_pos >= last_col);
    row_end = (row_pos >= last_row);
    res.done = col_end && row_end;
    if (col_end) begin
      col_pos = 0;
      row_pos = row_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  // Hold the sender off until every predicted pixel has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup then access phase; leave psel high so writes can run back to back
  task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, value);
  endtask

  task automatic program_reg(input reg_index_t idx, input logic [31:0] value);
    if (!bus_open) begin
      drain_results();
      bus_open = 1;
    end
    apb_write(idx, value);
  endtask

  // Drive one pixel beat and wait until it is taken; valid stays high afterwards
  task automatic send_pixel(input logic [7:0] b, g, r, input bit typed, input pixel_out_t want);
    pixel_out_t pred;
    if (bus_open) begin
      psel <= 1'b0;
      penable <= 1'b0;
      bus_open = 0;
    end
    in_valid <= 1'b1;
    src_blue <= b;
    src_green <= g;
    src_red <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_pixel(b, g, r);
    expected_pixels.push_back(typed ? want : pred);
  endtask

  function automatic void plan_write(input reg_index_t idx, input logic [31:0] value);
    plan_row_t row;
    row = '0;
    row.is_write = 1;
    row.idx = idx;
    row.value = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void plan_pixel(input logic [7:0] b, g, r);
    plan_row_t row;
    row = '0;
    row.blue = b;
    row.green = g;
    row.red = r;
    directed_rows.push_back(row);
  endfunction

  function automatic void plan_checked(input logic [7:0] b, g, r,
                                       input logic [OUT_ADDR_W-1:0] addr,
                                       input logic [7:0] want_b, want_g, want_r,
                                       input logic want_we, want_done);
    plan_row_t row;
    row = '0;
    row.blue = b;
    row.green = g;
    row.red = r;
    row.typed = 1;
    row.want = '{addr, want_b, want_g, want_r, want_we, want_done};
    directed_rows.push_back(row);
  endfunction

  function automatic logic [EXTENT_W-1:0] pick_extent();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0: return '0;
      1: return EXTENT_W'(COORD_SPAN);
      2: return {EXTENT_W{1'b1}};
      3: return EXTENT_W'($urandom_range(4097, 8190));
      4, 5, 6: return EXTENT_W'($urandom_range(7, 40));
      default: return EXTENT_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Rewrite a random subset of registers, extremes included now and then
  task automatic shuffle_config();
    int unsigned pick;
    logic [MODE_W-1:0] mode;
    if ($urandom_range(0, 4) < 3) begin
      pick = $urandom_range(0, 9);
      program_reg(REG_ROW_PITCH, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd16383 :
                  (pick == 2) ? 32'd1 : $urandom_range(1, 4096));
    end
    if ($urandom_range(0, 4) < 3) begin
      pick = $urandom_range(0, 9);
      program_reg(REG_BYTES_PER_PIXEL, (pick < 4) ? 32'd3 : (pick < 8) ? 32'd4 :
                  $urandom_range(0, 7));
    end
    if ($urandom_range(0, 4) < 3) begin
      pick = $urandom_range(0, 9);
      program_reg(REG_ORIGIN_X, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd4095 :
                  $urandom_range(0, 4095));
    end
    if ($urandom_range(0, 4) < 3) begin
      pick = $urandom_range(0, 9);
      program_reg(REG_ORIGIN_Y, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd4095 :
                  $urandom_range(0, 4095));
    end
    if ($urandom_range(0, 4) < 3) program_reg(REG_RECT_WIDTH, 32'(pick_extent()));
    if ($urandom_range(0, 4) < 3) program_reg(REG_RECT_HEIGHT, 32'(pick_extent()));
    if ($urandom_range(0, 4) < 3) begin
      pick = $urandom_range(0, 9);
      mode = (pick < 3) ? MODE_FILL : (pick < 6) ? MODE_GRAY :
             (pick < 9) ? MODE_BGR : MODE_SPARE;
      program_reg(REG_DRAW_MODE, 32'(mode));
    end
    if ($urandom_range(0, 4) < 3) program_reg(REG_FILL_COLOR, $urandom());
  endtask

  // Receiver stall pattern: free, light random, heavy random, periodic runs
  always @(posedge clk) begin
    stall_clock <= stall_clock + 1'b1;
    case (stall_clock[10:9])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_clock[5:3] == 3'd0);
    endcase
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    pixel_out_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{byte_address, out_blue, out_green, out_red, write_enable, rect_done};
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: unexpected pixel beat addr %h bgr %h %h %h we %b done %b",
                   $time, got.addr, got.blue, got.green, got.red, got.we, got.done);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (got.addr !== want.addr || got.blue !== want.blue || got.green !== want.green ||
            got.red !== want.red || got.we !== want.we || got.done !== want.done) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: pixel mismatch addr %h/%h bgr %h %h %h / %h %h %h we %b/%b done %b/%b",
                     $time, got.addr, want.addr, got.blue, got.green, got.red,
                     want.blue, want.green, want.red, got.we, want.we, got.done, want.done);
          end
        end
      end
    end
  end

  // Count cycles with no beat on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[framebuffer_rect_writer_top] ERROR");
    $finish;
  end

  initial begin
    int count, pause_at, burst, gap, phase;
    logic [7:0] b;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    src_blue <= '0;
    src_green <= '0;
    src_red <= '0;
    walk_cfg = '{row_pitch: 14'd3072, bytes_per_pixel: 3'd4, origin_x: '0, origin_y: '0,
                 rect_width: 13'd1, rect_height: 13'd1, draw_mode: MODE_FILL,
                 fill_color: '0};
    col_pos = 0;
    row_pos = 0;

    // Directed: reset defaults, small walk, every mode, degenerate and extreme settings
    plan_checked(8'hff, 8'hff, 8'hff, 26'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
    plan_write(REG_FILL_COLOR, 32'hab123456);
    plan_checked(8'h00, 8'h00, 8'h00, 26'd0, 8'h56, 8'h34, 8'h12, 1'b1, 1'b1);
    plan_write(REG_ROW_PITCH, 32'd100);
    plan_write(REG_BYTES_PER_PIXEL, 32'd3);
    plan_write(REG_ORIGIN_X, 32'd1);
    plan_write(REG_ORIGIN_Y, 32'd1);
    plan_write(REG_RECT_WIDTH, 32'd2);
    plan_write(REG_RECT_HEIGHT, 32'd2);
    plan_checked(8'h11, 8'h22, 8'h33, 26'd103, 8'h56, 8'h34, 8'h12, 1'b1, 1'b0);
    plan_checked(8'h11, 8'h22, 8'h33, 26'd106, 8'h56, 8'h34, 8'h12, 1'b1, 1'b0);
    plan_checked(8'h11, 8'h22, 8'h33, 26'd203, 8'h56, 8'h34, 8'h12, 1'b1, 1'b0);
    plan_checked(8'h11, 8'h22, 8'h33, 26'd206, 8'h56, 8'h34, 8'h12, 1'b1, 1'b1);
    plan_write(REG_DRAW_MODE, 32'(MODE_GRAY));
    plan_checked(TRANSPARENT_LEVEL, 8'haa, 8'h55, 26'd103, 8'h01, 8'h01, 8'h01, 1'b0, 1'b0);
    plan_pixel(8'h00, 8'hff, 8'hff);
    plan_pixel(8'hff, 8'h00, 8'h00);
    plan_pixel(8'h02, 8'h5a, 8'ha5);
    plan_write(REG_DRAW_MODE, 32'(MODE_BGR));
    plan_write(REG_RECT_WIDTH, 32'd3);
    plan_pixel(8'h00, 8'hff, 8'h00);
    plan_pixel(8'hff, 8'h00, 8'hff);
    plan_pixel(8'ha5, 8'h5a, 8'ha5);
    plan_pixel(8'h5a, 8'ha5, 8'h5a);
    plan_pixel(8'h01, 8'h80, 8'h7f);
    plan_pixel(8'h80, 8'h7f, 8'h01);
    plan_write(REG_DRAW_MODE, 32'(MODE_SPARE));
    plan_pixel(8'h12, 8'h34, 8'h56);
    plan_write(REG_RECT_WIDTH, 32'd0);
    plan_write(REG_RECT_HEIGHT, 32'd0);
    plan_pixel(8'h00, 8'h00, 8'h00);
    plan_pixel(8'hff, 8'hff, 8'hff);
    plan_write(REG_ROW_PITCH, 32'd16383);
    plan_write(REG_BYTES_PER_PIXEL, 32'd7);
    plan_write(REG_ORIGIN_X, 32'd4095);
    plan_write(REG_ORIGIN_Y, 32'd4095);
    plan_write(REG_RECT_WIDTH, 32'd8191);
    plan_write(REG_RECT_HEIGHT, 32'd4096);
    plan_write(REG_FILL_COLOR, 32'hffffff);
    plan_write(REG_DRAW_MODE, 32'(MODE_BGR));
    plan_pixel(8'hff, 8'hff, 8'hff);
    plan_pixel(8'h00, 8'h00, 8'h00);
    plan_write(REG_ROW_PITCH, 32'd0);
    plan_write(REG_BYTES_PER_PIXEL, 32'd0);
    plan_write(REG_RECT_WIDTH, 32'd4096);
    plan_write(REG_RECT_HEIGHT, 32'd1);
    plan_write(REG_DRAW_MODE, 32'(MODE_GRAY));
    plan_pixel(8'hc3, 8'h3c, 8'h99);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table back to back
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        program_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_pixel(directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red,
                   directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: new settings, then bursts of pixels with gaps
    phase = 0;
    while (random_sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 9) < 8) shuffle_config();
      count = $urandom_range(20, 100);
      pause_at = (phase == 0 || $urandom_range(0, 5) == 0) ? $urandom_range(1, count - 1) : -1;
      burst = $urandom_range(1, 40);
      for (int k = 0; k < count; k++) begin
        if (k == pause_at) begin
          drain_results();
        end else if (burst <= 0) begin
          gap = $urandom_range(0, 12);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst = $urandom_range(1, 40);
        end
        if (walk_cfg.draw_mode == MODE_GRAY) begin
          case ($urandom_range(0, 7))
            0, 1: b = TRANSPARENT_LEVEL;
            2: b = 8'h00;
            3: b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
          endcase
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_pixel(b, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, '0);
        burst--;
        random_sent++;
      end
      phase++;
    end

    // Let the pipeline empty, then report
    if (bus_open) begin
      psel <= 1'b0;
      penable <= 1'b0;
      bus_open = 0;
    end
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("[framebuffer_rect_writer_top] OK");
    end else begin
      $display("[framebuffer_rect_writer_top] ERROR");
    end
    $finish;
  end

endmodule

### framebuffer_rect_writer_top.f
rtl/frw_pkg.sv
rtl/frw_walker.sv
rtl/frw_pixel.sv
rtl/framebuffer_rect_writer_top.sv
tb/testbench.sv
